/* design/pli_pkg.sv */
`default_nettype none

package pli_pkg;

    // Field widths of the item formats
    localparam int DATA_W = 16;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_INV  = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic [IDX_W-1:0]          point_index;
        logic signed [DATA_W-1:0]  key_x;
        logic signed [DATA_W-1:0]  key_y;
    } t_item_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic                      found;
    } t_item_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_FIRST,
        S_F_LAST,
        S_F_SRCH,
        S_F_LO,
        S_F_HI,
        S_I_FIRST,
        S_I_SCAN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* design/piecewise_linear_interpolator_unit.sv */
`default_nettype none
// Load: writes one table entry (if the index is in range), no result. Forward: reads entry
// 0, the last entry, about log2(N) search entries and the two segment ends, then a multiply
// step and a restoring divide of the 32-bit product. Inverse: one table read per segment
// scanned (up to N-1) plus the same multiply and divide. The table memory port gives one
// read a cycle and the divider one quotient bit a cycle. One item at a time; the next
// item is taken in the cycle the result strobe shows, and the strobe cannot be stalled.
// Reset returns to idle, drops the strobe and clears point_count; tables keep contents.
module piecewise_linear_interpolator_unit
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_item_in          i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output t_item_out              o_result
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int PW = 2 * DATA_W;
    localparam int SW = PW + 2;
    localparam int DCW = $clog2(PW);

    function automatic logic signed [DATA_W:0] sub_ext(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        sub_ext = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W:0] v);
        logic signed [DATA_W:0] t;
        t   = (v < 0) ? -v : v;
        mag = t[DATA_W-1:0];
    endfunction

    // Table memories
    logic signed [DATA_W-1:0] r_x_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] r_y_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_point_count;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [CW-1:0]            r_n, n_n;
    logic [AW-1:0]            r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_i, n_i;
    logic signed [DATA_W-1:0] r_a0, n_a0, r_b0, n_b0, r_base, n_base;
    logic signed [DATA_W:0]   r_n1, n_n1, r_n2, n_n2, r_d, n_d;
    logic [PW-1:0]            r_prod, n_prod;
    logic                     r_neg, n_neg;
    logic [DATA_W-1:0]        r_dmag, n_dmag, r_rem, n_rem;
    logic [DCW-1:0]           r_cnt, n_cnt;
    logic                     r_strobe, n_strobe;
    t_item_out                r_res, n_res;

    logic                     accept;
    logic [CW-1:0]            cnt_now;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign wr_en    = accept && (i_item.cmd == CMD_LOAD)
                      && (32'(i_item.point_index) < MAX_POINTS);

    // Clamp the point count to the table depth
    always_comb begin
        if (32'(r_point_count) > MAX_POINTS) begin
            cnt_now = CW'(MAX_POINTS);
        end else begin
            cnt_now = CW'(r_point_count);
        end
    end

    // Write on load, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_x_mem[AW'(i_item.point_index)] <= i_item.key_x;
            r_y_mem[AW'(i_item.point_index)] <= i_item.key_y;
        end
        r_rd_x <= r_x_mem[rd_addr];
        r_rd_y <= r_y_mem[rd_addr];
    end

    // Sequencer: next state, read address and datapath updates
    always_comb begin
        logic [AW-1:0]           lo_v, hi_v;
        logic signed [DATA_W:0]  s_v;
        logic [DATA_W:0]         rem_sh;
        logic                    qbit;
        logic signed [SW-1:0]    delta, sum;
        n_state  = r_state;
        n_key    = r_key;
        n_n      = r_n;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_i      = r_i;
        n_a0     = r_a0;
        n_b0     = r_b0;
        n_base   = r_base;
        n_n1     = r_n1;
        n_n2     = r_n2;
        n_d      = r_d;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_dmag   = r_dmag;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_res    = r_res;
        rd_addr  = '0;
        lo_v     = r_lo;
        hi_v     = r_hi;
        s_v      = '0;
        rem_sh   = '0;
        qbit     = 1'b0;
        delta    = '0;
        sum      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n   = cnt_now;
                    n_key = (i_item.cmd == CMD_INV) ? i_item.key_y : i_item.key_x;
                    case (i_item.cmd)
                        CMD_FWD: begin
                            if (cnt_now == '0) begin
                                n_strobe    = 1'b1;
                                n_res.value = '0;
                                n_res.found = 1'b1;
                            end else begin
                                n_state = S_F_FIRST;
                            end
                        end
                        CMD_INV: begin
                            if (cnt_now < CW'(2)) begin
                                n_strobe    = 1'b1;
                                n_res.value = '0;
                                n_res.found = 1'b0;
                            end else begin
                                n_state = S_I_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Entry 0 is here: clamp below the first point
            S_F_FIRST: begin
                if (r_n == CW'(1) || r_key <= r_rd_x) begin
                    n_strobe    = 1'b1;
                    n_res.value = r_rd_y;
                    n_res.found = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    rd_addr = AW'(r_n - CW'(1));
                    n_state = S_F_LAST;
                end
            end

            // Last entry, then binary search steps
            S_F_LAST, S_F_SRCH: begin
                if (r_state == S_F_LAST) begin
                    lo_v = '0;
                    hi_v = AW'(r_n - CW'(1));
                end else if (r_rd_x <= r_key) begin
                    lo_v = r_mid;
                end else begin
                    hi_v = r_mid;
                end
                if (r_state == S_F_LAST && r_key >= r_rd_x) begin
                    n_strobe    = 1'b1;
                    n_res.value = r_rd_y;
                    n_res.found = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_lo = lo_v;
                    n_hi = hi_v;
                    if ((CW'(lo_v) + CW'(1)) < CW'(hi_v)) begin
                        n_mid   = AW'((CW'(lo_v) + CW'(hi_v)) >> 1);
                        rd_addr = n_mid;
                        n_state = S_F_SRCH;
                    end else begin
                        rd_addr = lo_v;
                        n_state = S_F_LO;
                    end
                end
            end

            S_F_LO: begin
                n_a0    = r_rd_x;
                n_b0    = r_rd_y;
                rd_addr = r_lo + AW'(1);
                n_state = S_F_HI;
            end

            S_F_HI: begin
                if (r_rd_x == r_a0) begin
                    n_strobe    = 1'b1;
                    n_res.value = r_b0;
                    n_res.found = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_n1    = sub_ext(r_key, r_a0);
                    n_n2    = sub_ext(r_rd_y, r_b0);
                    n_d     = sub_ext(r_rd_x, r_a0);
                    n_base  = r_b0;
                    n_state = S_MUL;
                end
            end

            S_I_FIRST: begin
                n_a0    = r_rd_x;
                n_b0    = r_rd_y;
                n_i     = AW'(1);
                rd_addr = AW'(1);
                n_state = S_I_SCAN;
            end

            // Test one segment for a span of the query y
            S_I_SCAN: begin
                if ((r_b0 <= r_key && r_key <= r_rd_y) || (r_rd_y <= r_key && r_key <= r_b0)) begin
                    if (r_rd_y == r_b0) begin
                        s_v         = $signed({r_a0[DATA_W-1], r_a0})
                                      + $signed({r_rd_x[DATA_W-1], r_rd_x});
                        s_v         = s_v >>> 1;
                        n_strobe    = 1'b1;
                        n_res.value = s_v[DATA_W-1:0];
                        n_res.found = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_n1    = sub_ext(r_key, r_b0);
                        n_n2    = sub_ext(r_rd_x, r_a0);
                        n_d     = sub_ext(r_rd_y, r_b0);
                        n_base  = r_a0;
                        n_state = S_MUL;
                    end
                end else if ((CW'(r_i) + CW'(1)) < r_n) begin
                    n_a0    = r_rd_x;
                    n_b0    = r_rd_y;
                    n_i     = r_i + AW'(1);
                    rd_addr = r_i + AW'(1);
                end else begin
                    n_strobe    = 1'b1;
                    n_res.value = '0;
                    n_res.found = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            S_MUL: begin
                n_prod  = mag(r_n1) * mag(r_n2);
                n_neg   = ((r_n1 < 0) ^ (r_n2 < 0)) ^ (r_d < 0);
                n_dmag  = mag(r_d);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end

            // Restoring divide, one quotient bit a cycle
            S_DIV: begin
                rem_sh = {r_rem, r_prod[PW-1]};
                if (rem_sh >= {1'b0, r_dmag}) begin
                    rem_sh = rem_sh - {1'b0, r_dmag};
                    qbit   = 1'b1;
                end
                n_rem  = rem_sh[DATA_W-1:0];
                n_prod = {r_prod[PW-2:0], qbit};
                n_cnt  = r_cnt + DCW'(1);
                if (r_cnt == DCW'(PW - 1)) begin
                    n_state = S_DONE;
                end
            end

            // Apply sign, add base, saturate
            S_DONE: begin
                delta = $signed({2'b00, r_prod});
                if (r_neg) begin
                    delta = -delta;
                end
                sum = delta + $signed({{(SW-DATA_W){r_base[DATA_W-1]}}, r_base});
                if (sum > $signed(SW'(16'sh7FFF))) begin
                    n_res.value = 16'sh7FFF;
                end else if (sum < $signed({{(SW-DATA_W){1'b1}}, 16'h8000})) begin
                    n_res.value = 16'sh8000;
                end else begin
                    n_res.value = sum[DATA_W-1:0];
                end
                n_res.found = 1'b1;
                n_strobe    = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_point_count <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_n    <= n_n;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_i    <= n_i;
        r_a0   <= n_a0;
        r_b0   <= n_b0;
        r_base <= n_base;
        r_n1   <= n_n1;
        r_n2   <= n_n2;
        r_d    <= n_d;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_dmag <= n_dmag;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

/* design/pli_checker.sv */
`default_nettype none

module pli_checker
    import pli_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_item_in  i_item,
    input wire logic      o_strobe
);

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

    // A result only follows work in progress or an accepted item
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("strobe without an item");

    // The block is free again when a result shows
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy with result");

    // A load gives no result and the block is idle again in the next cycle
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_LOAD) |=> (!o_strobe && !busy))
        else $error("load gave result or stayed busy");

endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe)
);

`default_nettype wire
